// File: hdl/obq_pkg.sv
package obq_pkg;

  // Queue geometry.
  localparam int DEPTH = 32;
  localparam int PC_W = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed port widths of the word fields.
  localparam int OP_W = 2;
  localparam int TAG_W = 5;
  localparam int STATUS_W = 2;
  localparam int OCC_W = 6;

  // Operation codes of an input word.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_RETIRE = 2'd1,
    OP_REPAIR = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Status codes of a result word.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADTAG = 2'd3
  } status_t;

  // One queue slot as held in the entry memory.
  typedef struct packed {
    logic            vld;
    logic            pat;
    logic [PC_W-1:0] pc;
  } entry_t;

  // Advance a slot pointer, wrapping from the last slot to the first.
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (int'(p) == DEPTH - 1) begin
      r = '0;
    end else begin
      r = p + IDX_W'(1);
    end
    return r;
  endfunction

endpackage

// File: hdl/outstanding_branch_queue_unit.sv
// Outstanding branch queue with predictor repair.
// A command word is taken on a rising edge where start is high and busy is
// low. Allocate writes pc, pattern and valid at the tail and returns the slot
// as alloc_tag; retire drops the oldest entry; repair reads the pc of the
// tagged slot and inverts the pattern bit of every entry from that slot to
// the youngest whose pc matches.
// Each command gives exactly one result word, shown for one cycle with
// out_strobe high; the receiver cannot stall, so the result is never held.
// Allocate, retire, rejected commands and the unused opcode give their result
// in the cycle after acceptance, and busy stays low, so one such command can be
// taken every cycle.
// A repair reads the tagged slot, then walks it and each younger entry in turn
// through the single read port of the entry memory, each entry read and
// written back in a pipelined read-modify-write. Busy is high while walking
// and the result comes in the cycle after the walk ends.
// Reset (rst_n low, synchronous) empties the queue and clears the pointers;
// the entry memory is not cleared, since only occupied slots are ever read.
module outstanding_branch_queue_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [obq_pkg::OP_W-1:0]      in_op,
  input  logic [31:0]                   in_pc,
  input  logic                          in_pattern,
  input  logic                          in_valid_req,
  input  logic [obq_pkg::TAG_W-1:0]     in_tag,
  output logic                          out_strobe,
  output logic [obq_pkg::STATUS_W-1:0]  out_status,
  output logic [obq_pkg::TAG_W-1:0]     out_alloc_tag,
  output logic [obq_pkg::OCC_W-1:0]     out_occupancy
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  // Entry memory with a registered read port.
  obq_pkg::entry_t mem [obq_pkg::DEPTH];
  obq_pkg::entry_t rd_data_r;

  logic                          rd_en;
  logic [obq_pkg::IDX_W-1:0]     rd_addr;
  logic                          wr_en;
  logic [obq_pkg::IDX_W-1:0]     wr_addr;
  obq_pkg::entry_t               wr_data;

  state_t                        state_r, state_nxt;
  logic [obq_pkg::IDX_W-1:0]     head_r, head_nxt;
  logic [obq_pkg::IDX_W-1:0]     tail_r, tail_nxt;
  logic [obq_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [obq_pkg::IDX_W-1:0]     addr_r, addr_nxt;
  logic [obq_pkg::CNT_W-1:0]     remain_r, remain_nxt;
  logic                          first_r, first_nxt;
  logic [obq_pkg::PC_W-1:0]      rpc_r, rpc_nxt;

  logic                          strobe_r, strobe_nxt;
  obq_pkg::status_t              status_r, status_nxt;
  logic [obq_pkg::TAG_W-1:0]     atag_r, atag_nxt;

  logic                          accept;
  logic                          tag_in_range;
  logic [obq_pkg::IDX_W-1:0]     tag_idx;
  logic [obq_pkg::CNT_W-1:0]     tag_off;
  logic [obq_pkg::PC_W-1:0]      cmp_pc;
  logic                          match;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Offset of the tagged slot from the head, modulo the queue depth.
  assign tag_in_range = (int'(in_tag) < obq_pkg::DEPTH);
  assign tag_idx      = obq_pkg::IDX_W'(in_tag);
  always_comb begin
    if (tag_idx >= head_r) begin
      tag_off = obq_pkg::CNT_W'(tag_idx - head_r);
    end else begin
      tag_off = obq_pkg::CNT_W'(obq_pkg::CNT_W'(tag_idx) + obq_pkg::CNT_W'(obq_pkg::DEPTH)
                                - obq_pkg::CNT_W'(head_r));
    end
  end

  // The first word of a walk is the tagged entry itself and sets the pc.
  assign cmp_pc = first_r ? rd_data_r.pc : rpc_r;
  assign match  = (rd_data_r.pc == cmp_pc);

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    addr_nxt   = addr_r;
    remain_nxt = remain_r;
    first_nxt  = first_r;
    rpc_nxt    = rpc_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    atag_nxt   = atag_r;
    rd_en      = 1'b0;
    rd_addr    = addr_r;
    wr_en      = 1'b0;
    wr_addr    = tail_r;
    wr_data    = '{vld: in_valid_req, pat: in_pattern, pc: obq_pkg::PC_W'(in_pc)};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt = obq_pkg::ST_OK;
          atag_nxt   = '0;
          case (in_op)
            obq_pkg::OP_ALLOC: begin
              strobe_nxt = 1'b1;
              if (int'(count_r) >= obq_pkg::DEPTH) begin
                status_nxt = obq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                atag_nxt  = obq_pkg::TAG_W'(tail_r);
                tail_nxt  = obq_pkg::next_slot(tail_r);
                count_nxt = count_r + obq_pkg::CNT_W'(1);
              end
            end
            obq_pkg::OP_RETIRE: begin
              strobe_nxt = 1'b1;
              if (count_r == '0) begin
                status_nxt = obq_pkg::ST_EMPTY;
              end else begin
                head_nxt  = obq_pkg::next_slot(head_r);
                count_nxt = count_r - obq_pkg::CNT_W'(1);
              end
            end
            obq_pkg::OP_REPAIR: begin
              if (!tag_in_range || (tag_off >= count_r)) begin
                strobe_nxt = 1'b1;
                status_nxt = obq_pkg::ST_BADTAG;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = tag_idx;
                addr_nxt   = tag_idx;
                remain_nxt = count_r - tag_off - obq_pkg::CNT_W'(1);
                first_nxt  = 1'b1;
                state_nxt  = S_WALK;
              end
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      S_WALK: begin
        // Write back the word in hand, flipped where its pc matches.
        rpc_nxt   = cmp_pc;
        first_nxt = 1'b0;
        wr_en     = match;
        wr_addr   = addr_r;
        wr_data   = '{vld: rd_data_r.vld, pat: ~rd_data_r.pat, pc: rd_data_r.pc};
        // Fetch the next younger entry, or finish.
        if (remain_r != '0) begin
          rd_en      = 1'b1;
          rd_addr    = obq_pkg::next_slot(addr_r);
          addr_nxt   = obq_pkg::next_slot(addr_r);
          remain_nxt = remain_r - obq_pkg::CNT_W'(1);
        end else begin
          strobe_nxt = 1'b1;
          status_nxt = obq_pkg::ST_OK;
          atag_nxt   = '0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Walk and result payload.
  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    remain_r <= remain_nxt;
    first_r  <= first_nxt;
    rpc_r    <= rpc_nxt;
    status_r <= status_nxt;
    atag_r   <= atag_nxt;
  end

  assign out_strobe    = strobe_r;
  assign out_status    = status_r;
  assign out_alloc_tag = atag_r;
  assign out_occupancy = obq_pkg::OCC_W'(count_r);

endmodule

// File: hdl/obq_checker.sv
module obq_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [obq_pkg::OP_W-1:0]      in_op,
  input  logic                          out_strobe,
  input  logic [obq_pkg::STATUS_W-1:0]  out_status,
  input  logic [obq_pkg::TAG_W-1:0]     out_alloc_tag,
  input  logic [obq_pkg::OCC_W-1:0]     out_occupancy
);

  // A result word only follows an accepted command or a running walk.
  a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(start && !busy) || $past(busy)))
    else $error("result word without a command");

  // Commands other than repair answer in the next cycle.
  a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op != obq_pkg::OP_REPAIR)) |=> out_strobe)
    else $error("missing result word");

  // A full report only comes from a full queue.
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == obq_pkg::ST_FULL))
      |-> (int'(out_occupancy) == obq_pkg::DEPTH))
    else $error("full reported below depth");

  // Occupancy never exceeds the queue depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (int'(out_occupancy) <= obq_pkg::DEPTH))
    else $error("occupancy over depth");

  // A rejected command carries no slot tag.
  a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != obq_pkg::ST_OK)) |-> (out_alloc_tag == '0))
    else $error("tag on a rejected command");

endmodule

bind outstanding_branch_queue_unit obq_checker u_obq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_op         (in_op),
  .out_strobe    (out_strobe),
  .out_status    (out_status),
  .out_alloc_tag (out_alloc_tag),
  .out_occupancy (out_occupancy)
);
